// ===== design/bitmap_frame_allocator_unit_macros.svh =====
// assertion macros shared by the frame allocator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/bfa_pkg.sv =====
// shared constants, types and helper functions of the frame allocator
// no dependencies; used by every module of the block
package bfa_pkg;

    // bitmap geometry
    localparam int unsigned WORDS     = 128;
    localparam int unsigned WORD_AW   = 7;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_AW    = 5;
    localparam int unsigned FRAME_W   = WORD_AW + BIT_AW;

    // search tree: groups of words
    localparam int unsigned GRP_SIZE = 8;
    localparam int unsigned GRP_AW   = 3;
    localparam int unsigned GRPS     = WORDS / GRP_SIZE;
    localparam int unsigned GRPS_AW  = WORD_AW - GRP_AW;

    // word limit register
    localparam int unsigned LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // transaction kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MAPPED  = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // full-flag update after a bitmap write
    typedef struct packed {
        logic               valid;
        logic [WORD_AW-1:0] word;
        logic               full;
    } t_full_upd;

    // index of the lowest clear bit of a word
    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] oh;
        logic [BIT_AW-1:0]    idx;
        oh  = ~w & (w + WORD_BITS'(1));
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                idx = idx | BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/bitmap_frame_allocator_unit.sv =====
// First-fit page frame allocator over a 4096-frame bitmap (128 words of 32 bits,
// all frames free after reset). Pulse start while busy is low; exactly one result
// follows, shown for one cycle with o_done high, and it cannot be held off.
// An allocate transaction with a nonzero current frame, or a free transaction
// with an address beyond the bitmap, answers in the cycle after start and leaves
// busy low. A free reads the bitmap word from the ram on start and writes it
// back in the write-back state. An allocation registers the per-group summary
// of the per-word full flags, then picks the word and reads it from the ram,
// then encodes the lowest clear bit and writes the word back.
// An allocation that finds every searched word full ends after the pick.
// The word limit may be written whenever no transaction is in flight.
// depends on bfa_pkg, bfa_word_search, bfa_bitmap_ram and the macro header
`include "bitmap_frame_allocator_unit_macros.svh"

module bitmap_frame_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_kind,
    input  logic [19:0] i_current_frame,
    input  logic        i_is_kernel,
    input  logic        i_is_writable,
    input  logic [31:0] i_free_address,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_frame_index,
    output logic        o_present,
    output logic        o_writable,
    output logic        o_user_access
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_MOD  = 2'd3;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic [bfa_pkg::LIMIT_W-1:0]         r_limit;
    logic                                r_kind;
    logic                                r_kernel;
    logic                                r_writable;
    logic [bfa_pkg::WORD_AW-1:0]         r_word;
    logic [bfa_pkg::BIT_AW-1:0]          r_bit;
    logic                                r_done;
    logic [1:0]                          r_status;
    logic [bfa_pkg::FRAME_W-1:0]         r_frame;
    logic                                r_present;
    logic                                r_wr_out;
    logic                                r_user;

    logic                                accept;
    logic                                mapped;
    logic                                out_of_range;
    logic                                found;
    logic [bfa_pkg::WORD_AW-1:0]         found_word;
    logic                                ram_re;
    logic [bfa_pkg::WORD_AW-1:0]         ram_raddr;
    logic [bfa_pkg::WORD_BITS-1:0]       ram_rdata;
    logic [bfa_pkg::WORD_BITS-1:0]       ram_wdata;
    logic [bfa_pkg::BIT_AW-1:0]          free_bit;
    bfa_pkg::t_full_upd                  full_upd;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign mapped       = (i_current_frame != 20'd0);
    assign out_of_range = (i_free_address[31:24] != 8'd0);

    // word limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bfa_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // word search over the full flags
    bfa_word_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (r_state == S_SCAN),
        .i_limit (r_limit),
        .i_upd   (full_upd),
        .o_found (found),
        .o_word  (found_word)
    );

    // ram read: free address on accept, picked word on allocation
    assign ram_re    = (accept && (i_kind == bfa_pkg::KIND_FREE) && !out_of_range)
                    || ((r_state == S_PICK) && found);
    assign ram_raddr = (r_state == S_PICK) ? found_word : i_free_address[23:17];

    // read-modify-write of the selected word
    assign free_bit  = bfa_pkg::lowest_zero(ram_rdata);
    assign ram_wdata = (r_kind == bfa_pkg::KIND_ALLOC)
                     ? (ram_rdata | (bfa_pkg::WORD_BITS'(1) << free_bit))
                     : (ram_rdata & ~(bfa_pkg::WORD_BITS'(1) << r_bit));

    assign full_upd.valid = (r_state == S_MOD);
    assign full_upd.word  = r_word;
    assign full_upd.full  = &ram_wdata;

    bfa_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_state == S_MOD),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == bfa_pkg::KIND_ALLOC) begin
                        n_state = mapped ? S_IDLE : S_SCAN;
                    end else begin
                        n_state = out_of_range ? S_IDLE : S_MOD;
                    end
                end
            end
            S_SCAN:  n_state = S_PICK;
            S_PICK:  n_state = found ? S_MOD : S_IDLE;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (accept && (i_kind == bfa_pkg::KIND_ALLOC) && mapped)
                    || (accept && (i_kind == bfa_pkg::KIND_FREE) && out_of_range)
                    || ((r_state == S_PICK) && !found)
                    || (r_state == S_MOD);
        end
    end

    // transaction fields and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_kind;
            r_kernel   <= i_is_kernel;
            r_writable <= i_is_writable;
            r_word     <= i_free_address[23:17];
            r_bit      <= i_free_address[16:12];
            r_status   <= (i_kind == bfa_pkg::KIND_ALLOC) ? bfa_pkg::ST_MAPPED
                                                          : bfa_pkg::ST_RANGE;
            r_frame    <= '0;
            r_present  <= 1'b0;
            r_wr_out   <= 1'b0;
            r_user     <= 1'b0;
        end
        if (r_state == S_PICK) begin
            r_word   <= found_word;
            r_status <= bfa_pkg::ST_NO_FREE;
        end
        if (r_state == S_MOD) begin
            r_status <= bfa_pkg::ST_OK;
            if (r_kind == bfa_pkg::KIND_ALLOC) begin
                r_frame   <= {r_word, free_bit};
                r_present <= 1'b1;
                r_wr_out  <= r_writable;
                r_user    <= !r_kernel;
            end else begin
                r_frame <= {r_word, r_bit};
            end
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_frame_index = r_frame;
    assign o_present     = r_present;
    assign o_writable    = r_wr_out;
    assign o_user_access = r_user;

    // error results carry no frame and no page bits
    `BFA_ASSERT_IMPLY(a_err_clean, i_clk, i_rst_n, o_done && (o_status != bfa_pkg::ST_OK), (o_frame_index == '0) && !o_present && !o_writable && !o_user_access)
    // the write-back cycle is always followed by a result
    `BFA_ASSERT_NEXT(a_mod_done, i_clk, i_rst_n, r_state == S_MOD, o_done && (o_status == bfa_pkg::ST_OK))
    // a picked word lies below the word limit
    `BFA_ASSERT_IMPLY(a_pick_limit, i_clk, i_rst_n, (r_state == S_PICK) && found, bfa_pkg::LIMIT_W'(found_word) < r_limit)
    // full flags agree with the ram: an allocated word has a clear bit
    `BFA_ASSERT_IMPLY(a_word_not_full, i_clk, i_rst_n, (r_state == S_MOD) && (r_kind == bfa_pkg::KIND_ALLOC), ram_rdata != '1)
    // a result is shown only while idle or in the scan state
    `BFA_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, (r_state == S_IDLE) || (r_state == S_SCAN))

endmodule

// ===== design/bfa_bitmap_ram.sv =====
// frame bitmap storage: synchronous ram with registered read and per-word valid bits
// depends on bfa_pkg; words never written since reset read as zero
module bfa_bitmap_ram (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [bfa_pkg::WORD_AW-1:0]     i_waddr,
    input  logic [bfa_pkg::WORD_BITS-1:0]   i_wdata,
    input  logic                            i_re,
    input  logic [bfa_pkg::WORD_AW-1:0]     i_raddr,
    output logic [bfa_pkg::WORD_BITS-1:0]   o_rdata
);

    logic [bfa_pkg::WORD_BITS-1:0] r_mem [bfa_pkg::WORDS];
    logic [bfa_pkg::WORDS-1:0]     r_valid;
    logic [bfa_pkg::WORD_BITS-1:0] r_rdata;
    logic                          r_rd_valid;

    // array write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // written-since-reset flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

// ===== design/bfa_word_search.sv =====
// per-word full flags and a two-level registered search for the first
// word with a clear bit below the word limit; depends on bfa_pkg
module bfa_word_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_scan,
    input  logic [bfa_pkg::LIMIT_W-1:0]     i_limit,
    input  bfa_pkg::t_full_upd              i_upd,
    output logic                            o_found,
    output logic [bfa_pkg::WORD_AW-1:0]     o_word
);

    logic [bfa_pkg::WORDS-1:0]  r_full;
    logic [bfa_pkg::WORDS-1:0]  elig;
    logic [bfa_pkg::GRPS-1:0]   n_grp_any;
    logic [bfa_pkg::GRP_AW-1:0] n_grp_low [bfa_pkg::GRPS];
    logic [bfa_pkg::GRPS-1:0]   r_grp_any;
    logic [bfa_pkg::GRP_AW-1:0] r_grp_low [bfa_pkg::GRPS];
    logic [bfa_pkg::GRPS-1:0]   grp_oh;
    logic [bfa_pkg::GRPS_AW-1:0] grp_sel;

    // full flags follow every bitmap write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd.valid) begin
            r_full[i_upd.word] <= i_upd.full;
        end
    end

    // words that are searched and not full
    always_comb begin
        for (int w = 0; w < bfa_pkg::WORDS; w++) begin
            elig[w] = !r_full[w] && (bfa_pkg::LIMIT_W'(w) < i_limit);
        end
    end

    // first level: any eligible word and its lowest position per group
    always_comb begin
        for (int g = 0; g < bfa_pkg::GRPS; g++) begin
            n_grp_any[g] = |elig[g*bfa_pkg::GRP_SIZE +: bfa_pkg::GRP_SIZE];
            n_grp_low[g] = '0;
            for (int k = bfa_pkg::GRP_SIZE - 1; k >= 0; k--) begin
                if (elig[g*bfa_pkg::GRP_SIZE + k]) begin
                    n_grp_low[g] = bfa_pkg::GRP_AW'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan) begin
            r_grp_any <= n_grp_any;
            r_grp_low <= n_grp_low;
        end
    end

    // second level: lowest group with an eligible word
    always_comb begin
        grp_oh  = r_grp_any & (~r_grp_any + bfa_pkg::GRPS'(1));
        grp_sel = '0;
        for (int g = 0; g < bfa_pkg::GRPS; g++) begin
            if (grp_oh[g]) begin
                grp_sel = grp_sel | bfa_pkg::GRPS_AW'(g);
            end
        end
    end

    assign o_found = |r_grp_any;
    assign o_word  = {grp_sel, r_grp_low[grp_sel]};

endmodule
